// File: rtl/core/bbsut_pkg.sv
// Shared types and constants for the buffered bit-serial UART transmitter.
// Used by bbsut_frame and buffered_bit_serial_uart_tx.
package bbsut_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 10;

    localparam int OP_W  = 2;
    localparam int POS_W = 4;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_START = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    localparam logic [POS_W-1:0] POS_START = 4'd0;
    localparam logic [POS_W-1:0] POS_DATA_LAST = 4'd8;
    localparam logic [POS_W-1:0] POS_STOP  = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [7:0]      data_byte;
        logic            last_of_batch;
    } t_in_item;

    typedef struct packed {
        logic tx_level;
        logic busy_res;
        logic frame_done;
        logic batch_rejected;
    } t_out_item;

    // Controls from the sequencer to the frame shifter.
    typedef struct packed {
        logic       tick;
        logic       clear_pos;
        logic       fill;
        logic       fix;
        logic [7:0] fix_byte;
    } t_frame_ctl;

    // Frame position status back to the sequencer.
    typedef struct packed {
        logic at_start;
        logic in_data;
        logic at_stop;
        logic beyond;
    } t_frame_sts;

endpackage

// File: rtl/core/bbsut_store.sv
// Character store: one write port and one registered read port.
// Depends on nothing outside this file.
module bbsut_store #(
    parameter int DEPTH  = 10,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/bbsut_frame.sv
// Frame shifter: bit position counter, data shift register and line level.
// Depends on bbsut_pkg.
module bbsut_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bbsut_pkg::t_frame_ctl i_ctl,
    input  logic [7:0]          i_fill_byte,
    output bbsut_pkg::t_frame_sts o_sts,
    output logic                o_line
);

    import bbsut_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_shift, n_shift;
    logic             r_line, n_line;
    logic [2:0]       w_fix_sh;

    assign o_sts.at_start = (r_pos == POS_START);
    assign o_sts.in_data  = (r_pos != POS_START) && (r_pos <= POS_DATA_LAST);
    assign o_sts.at_stop  = (r_pos == POS_STOP);
    assign o_sts.beyond   = (r_pos > POS_STOP);

    assign w_fix_sh = 3'(r_pos - 4'd1);

    always_comb begin
        n_pos   = r_pos;
        n_shift = r_shift;
        n_line  = r_line;
        if (i_ctl.fill) begin
            n_shift = i_fill_byte;
        end
        // A byte rewritten mid-frame replaces the bits not yet sent.
        if (i_ctl.fix) begin
            n_shift = i_ctl.fix_byte >> w_fix_sh;
        end
        if (i_ctl.clear_pos) begin
            n_pos = POS_START;
        end else if (i_ctl.tick) begin
            if (o_sts.at_start) begin
                n_line = 1'b0;
                n_pos  = r_pos + 4'd1;
            end else if (o_sts.in_data) begin
                n_line  = r_shift[0];
                n_shift = {1'b0, r_shift[7:1]};
                n_pos   = r_pos + 4'd1;
            end else if (o_sts.at_stop) begin
                n_line = 1'b1;
                n_pos  = POS_START;
            end else begin
                n_pos = POS_START;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_START;
            r_line <= 1'b1;
        end else begin
            r_pos  <= n_pos;
            r_line <= n_line;
        end
        r_shift <= n_shift;
    end

    assign o_line = r_line;

endmodule

// File: rtl/core/buffered_bit_serial_uart_tx.sv
// Top level of the buffered bit-serial 8N1 UART transmitter.
// Depends on bbsut_pkg, bbsut_store and bbsut_frame.
//
// Usage: an item (op, data_byte, last_of_batch) is transferred at a rising
// edge where start is high and busy is low. Each item gives exactly one
// result, shown on o_item for one cycle with o_valid high, in the cycle
// after the transfer; the receiver must take it then.
// Load items append bytes to the character store and stop sending; the
// load marked last_of_batch commits the batch, or rejects it when it was
// longer than BUFFER_DEPTH. A start item enables sending. Each tick item
// drives one line bit: start bit, eight data bits LSB first, stop bit,
// characters going out from the last loaded to the first.
// Throughput: one item per cycle, except that the tick driving a start bit
// holds busy high while the character is read from the store into the
// shift register.
// Reset (synchronous, active low) idles the line high, clears the count,
// the load pointer and the bit position. The store is not cleared.
module buffered_bit_serial_uart_tx #(
    parameter int BUFFER_DEPTH = bbsut_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  bbsut_pkg::t_in_item  i_item,
    output logic                 busy,
    output logic                 o_valid,
    output bbsut_pkg::t_out_item o_item
);

    import bbsut_pkg::*;

    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_lp, n_lp;
    logic [CNT_W-1:0] r_chars, n_chars;
    logic             r_en, n_en;
    logic             r_ovf, n_ovf;
    logic             r_valid, n_valid;
    logic             r_done, n_done;
    logic             r_rej, n_rej;

    logic              w_accept;
    logic              w_we;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [CNT_W-1:0]  w_idx;
    logic [7:0]        w_rd_data;
    logic              w_line;
    t_frame_ctl        w_ctl;
    t_frame_sts        w_sts;

    assign w_accept  = start && (r_state == S_IDLE);
    assign w_idx     = r_chars - CNT_W'(1);
    assign w_rd_addr = (r_chars != '0) ? w_idx[ADDR_W-1:0] : '0;
    assign w_wr_addr = r_lp[ADDR_W-1:0];
    assign w_we      = w_accept && (i_item.op == OP_LOAD) && (r_lp < DEPTH_C);

    always_comb begin
        n_state = r_state;
        n_lp    = r_lp;
        n_chars = r_chars;
        n_en    = r_en;
        n_ovf   = r_ovf;
        n_valid = w_accept;
        n_done  = 1'b0;
        n_rej   = 1'b0;
        w_ctl   = '0;
        w_ctl.fix_byte = i_item.data_byte;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_item.op)
                        OP_LOAD: begin
                            n_en = 1'b0;
                            if (w_we) begin
                                n_lp = r_lp + CNT_W'(1);
                                // Keep the shift register in step when the
                                // character now in flight is overwritten.
                                w_ctl.fix = (r_chars != '0) && (w_idx == r_lp)
                                            && w_sts.in_data;
                            end else begin
                                n_ovf = 1'b1;
                            end
                            if (i_item.last_of_batch) begin
                                if (!w_we) begin
                                    n_chars = '0;
                                    n_rej   = 1'b1;
                                end else if (r_ovf) begin
                                    n_chars = '0;
                                    n_rej   = 1'b1;
                                end else begin
                                    n_chars = n_lp;
                                end
                                n_lp  = '0;
                                n_ovf = 1'b0;
                                w_ctl.clear_pos = 1'b1;
                            end
                        end
                        OP_START: begin
                            n_en = 1'b1;
                        end
                        OP_TICK: begin
                            if (r_en && (r_chars != '0)) begin
                                w_ctl.tick = 1'b1;
                                if (w_sts.at_start) begin
                                    n_state = S_FETCH;
                                end else if (w_sts.at_stop) begin
                                    n_done = 1'b1;
                                    n_chars = r_chars - CNT_W'(1);
                                    if (r_chars == CNT_W'(1)) begin
                                        n_en = 1'b0;
                                    end
                                end else if (w_sts.beyond) begin
                                    n_en    = 1'b0;
                                    n_chars = '0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                w_ctl.fill = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lp    <= '0;
            r_chars <= '0;
            r_en    <= 1'b0;
            r_ovf   <= 1'b0;
            r_valid <= 1'b0;
            r_done  <= 1'b0;
            r_rej   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lp    <= n_lp;
            r_chars <= n_chars;
            r_en    <= n_en;
            r_ovf   <= n_ovf;
            r_valid <= n_valid;
            r_done  <= n_done;
            r_rej   <= n_rej;
        end
    end

    bbsut_store #(
        .DEPTH  (BUFFER_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_item.data_byte),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    bbsut_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_fill_byte (w_rd_data),
        .o_sts       (w_sts),
        .o_line      (w_line)
    );

    assign busy    = (r_state == S_FETCH);
    assign o_valid = r_valid;

    assign o_item.tx_level       = w_line;
    assign o_item.busy_res       = r_en && (r_chars != '0);
    assign o_item.frame_done     = r_done;
    assign o_item.batch_rejected = r_rej;

endmodule
